// ===== hdl/alle_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// alle_pkg: shared types and constants for the array linked list engine
// Command and result payloads, operation and status codes, RAM port bundles
// and the sequencer state type.
// ----------------------------------------------------------------------------
package alle_pkg;

    // Table geometry: slot fields are 8 bits wide, so the table has 256 entries
    localparam int SLOT_BITS   = 8;
    localparam int TABLE_DEPTH = 1 << SLOT_BITS;
    localparam int SLOTS       = 256;
    localparam int VALUE_BITS  = 32;
    localparam int FRESH_BITS  = SLOT_BITS + 1;

    // First slot index that is never handed out
    localparam logic [FRESH_BITS-1:0] FRESH_LIMIT = FRESH_BITS'(SLOTS);
    localparam logic [FRESH_BITS-1:0] FRESH_RESET = FRESH_BITS'(1);
    localparam logic [FRESH_BITS-1:0] FRESH_INIT  = FRESH_BITS'(2);

    localparam logic [SLOT_BITS-1:0] SLOT_NONE  = '0;
    localparam logic [SLOT_BITS-1:0] SLOT_FIRST = SLOT_BITS'(1);

    // Operation codes; codes above read act as read
    localparam logic [2:0] MODE_INIT   = 3'd0;
    localparam logic [2:0] MODE_AFTER  = 3'd1;
    localparam logic [2:0] MODE_BEFORE = 3'd2;
    localparam logic [2:0] MODE_DELETE = 3'd3;
    localparam logic [2:0] MODE_READ   = 3'd4;

    // Result status codes
    localparam logic [1:0] STAT_OK   = 2'd0;
    localparam logic [1:0] STAT_FULL = 2'd1;
    localparam logic [1:0] STAT_BAD  = 2'd2;

    typedef struct packed {
        logic [2:0]                   mode;
        logic [SLOT_BITS-1:0]         place;
        logic signed [VALUE_BITS-1:0] value;
    } t_cmd;

    typedef struct packed {
        logic [1:0]                   status;
        logic [SLOT_BITS-1:0]         slot;
        logic signed [VALUE_BITS-1:0] slot_value;
        logic [SLOT_BITS-1:0]         next_slot;
        logic [SLOT_BITS-1:0]         prev_slot;
        logic [SLOT_BITS-1:0]         head_slot;
        logic [SLOT_BITS-1:0]         tail_slot;
        logic [SLOT_BITS-1:0]         element_count;
    } t_result;

    // Port bundle of one link memory
    typedef struct packed {
        logic                 we;
        logic [SLOT_BITS-1:0] waddr;
        logic [SLOT_BITS-1:0] wdata;
        logic [SLOT_BITS-1:0] raddr;
    } t_link_port;

    // Port bundle of the value memory
    typedef struct packed {
        logic                  we;
        logic [SLOT_BITS-1:0]  waddr;
        logic [VALUE_BITS-1:0] wdata;
        logic [SLOT_BITS-1:0]  raddr;
    } t_val_port;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_LOOK,
        ST_TAKE,
        ST_WR1,
        ST_WR2
    } t_state;

endpackage

// ===== hdl/alle_ram.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// alle_ram: generic single-port-write, single-port-read RAM
// One write and one read per cycle; read data registered.
// ----------------------------------------------------------------------------
module alle_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // write port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // registered read port
    always_ff @(posedge i_clk) begin
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// ===== hdl/alle_seq.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// alle_seq: operation sequencer of the linked list engine
// Reads the place entry, takes a slot from the freed stack or the fresh
// mark, then writes the new or cleared entry and the neighbor links.
// ----------------------------------------------------------------------------
module alle_seq (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            start,
    output logic                            busy,
    input  alle_pkg::t_cmd                  i_cmd,
    output alle_pkg::t_result               o_result,
    output logic                            o_done,
    output alle_pkg::t_link_port            o_fwd_port,
    output alle_pkg::t_link_port            o_bwd_port,
    output alle_pkg::t_val_port             o_val_port,
    input  logic [alle_pkg::SLOT_BITS-1:0]  i_fwd_rdata,
    input  logic [alle_pkg::SLOT_BITS-1:0]  i_bwd_rdata,
    input  logic [alle_pkg::VALUE_BITS-1:0] i_val_rdata
);

    alle_pkg::t_state r_state, n_state;

    // captured command
    logic [2:0]                          r_mode;
    logic [alle_pkg::SLOT_BITS-1:0]      r_place;
    logic [alle_pkg::VALUE_BITS-1:0]     r_value;

    // working links and the slot being inserted
    logic [alle_pkg::SLOT_BITS-1:0]      r_nx, n_nx;
    logic [alle_pkg::SLOT_BITS-1:0]      r_pv, n_pv;
    logic [alle_pkg::SLOT_BITS-1:0]      r_new, n_new;

    // list bookkeeping
    logic [alle_pkg::SLOT_BITS-1:0]      r_first, n_first;
    logic [alle_pkg::SLOT_BITS-1:0]      r_last, n_last;
    logic [alle_pkg::SLOT_BITS-1:0]      r_count, n_count;
    logic [alle_pkg::SLOT_BITS-1:0]      r_freed_top, n_freed_top;
    logic [alle_pkg::FRESH_BITS-1:0]     r_fresh, n_fresh;
    logic [alle_pkg::TABLE_DEPTH-1:0]    r_in_use, n_in_use;

    // result register
    logic                                r_done, n_done;
    logic [1:0]                          r_res_status, n_res_status;
    logic [alle_pkg::SLOT_BITS-1:0]      r_res_slot, n_res_slot;
    logic [alle_pkg::VALUE_BITS-1:0]     r_res_sval, n_res_sval;
    logic [alle_pkg::SLOT_BITS-1:0]      r_res_nx, n_res_nx;
    logic [alle_pkg::SLOT_BITS-1:0]      r_res_pv, n_res_pv;

    logic is_elem;
    logic is_insert;
    logic is_read;
    logic have_freed;
    logic have_fresh;

    assign is_elem    = (r_place != alle_pkg::SLOT_NONE)
                        && ({1'b0, r_place} < alle_pkg::FRESH_LIMIT)
                        && r_in_use[r_place];
    assign is_insert  = (r_mode == alle_pkg::MODE_AFTER) || (r_mode == alle_pkg::MODE_BEFORE);
    assign is_read    = !is_insert && (r_mode != alle_pkg::MODE_INIT)
                        && (r_mode != alle_pkg::MODE_DELETE);
    assign have_freed = (r_freed_top != alle_pkg::SLOT_NONE);
    assign have_fresh = (r_fresh < alle_pkg::FRESH_LIMIT);

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            alle_pkg::ST_IDLE: begin
                if (start) begin
                    n_state = alle_pkg::ST_LOOK;
                end
            end
            alle_pkg::ST_LOOK: begin
                if (r_mode == alle_pkg::MODE_INIT || !is_elem || is_read) begin
                    n_state = alle_pkg::ST_IDLE;
                end else if (r_mode == alle_pkg::MODE_DELETE) begin
                    n_state = alle_pkg::ST_WR1;
                end else if (have_freed) begin
                    n_state = alle_pkg::ST_TAKE;
                end else if (have_fresh) begin
                    n_state = alle_pkg::ST_WR1;
                end else begin
                    n_state = alle_pkg::ST_IDLE;
                end
            end
            alle_pkg::ST_TAKE: n_state = alle_pkg::ST_WR1;
            alle_pkg::ST_WR1:  n_state = alle_pkg::ST_WR2;
            alle_pkg::ST_WR2:  n_state = alle_pkg::ST_IDLE;
            default:           n_state = alle_pkg::ST_IDLE;
        endcase
    end

    // memory ports and busy
    always_comb begin
        busy       = (r_state != alle_pkg::ST_IDLE);
        o_fwd_port = '{we: 1'b0, waddr: r_place, wdata: r_nx, raddr: r_place};
        o_bwd_port = '{we: 1'b0, waddr: r_place, wdata: r_pv, raddr: r_place};
        o_val_port = '{we: 1'b0, waddr: r_place, wdata: r_value, raddr: r_place};
        case (r_state)
            alle_pkg::ST_IDLE: begin
                // look up the place entry of the incoming command
                o_fwd_port.raddr = i_cmd.place;
                o_bwd_port.raddr = i_cmd.place;
                o_val_port.raddr = i_cmd.place;
            end
            alle_pkg::ST_LOOK: begin
                // pop link of the freed stack
                o_fwd_port.raddr = r_freed_top;
                if (r_mode == alle_pkg::MODE_INIT) begin
                    o_val_port = '{we: 1'b1, waddr: alle_pkg::SLOT_FIRST, wdata: r_value,
                                   raddr: r_place};
                    o_fwd_port.we    = 1'b1;
                    o_fwd_port.waddr = alle_pkg::SLOT_FIRST;
                    o_fwd_port.wdata = alle_pkg::SLOT_NONE;
                    o_bwd_port.we    = 1'b1;
                    o_bwd_port.waddr = alle_pkg::SLOT_FIRST;
                    o_bwd_port.wdata = alle_pkg::SLOT_NONE;
                end
            end
            alle_pkg::ST_WR1: begin
                o_fwd_port.we = 1'b1;
                o_bwd_port.we = 1'b1;
                o_val_port.we = 1'b1;
                if (is_insert) begin
                    // fill the new entry
                    o_val_port.waddr = r_new;
                    o_fwd_port.waddr = r_new;
                    o_bwd_port.waddr = r_new;
                end else begin
                    // clear the deleted entry and push it on the freed stack
                    o_val_port.wdata = '0;
                    o_fwd_port.wdata = r_freed_top;
                    o_bwd_port.wdata = alle_pkg::SLOT_NONE;
                end
            end
            alle_pkg::ST_WR2: begin
                if (r_mode == alle_pkg::MODE_AFTER) begin
                    o_fwd_port = '{we: 1'b1, waddr: r_place, wdata: r_new, raddr: r_place};
                    o_bwd_port = '{we: (r_nx != alle_pkg::SLOT_NONE), waddr: r_nx,
                                   wdata: r_new, raddr: r_place};
                end else if (r_mode == alle_pkg::MODE_BEFORE) begin
                    o_bwd_port = '{we: 1'b1, waddr: r_place, wdata: r_new, raddr: r_place};
                    o_fwd_port = '{we: (r_pv != alle_pkg::SLOT_NONE), waddr: r_pv,
                                   wdata: r_new, raddr: r_place};
                end else begin
                    // join the former neighbors of the deleted slot
                    o_fwd_port = '{we: (r_pv != alle_pkg::SLOT_NONE), waddr: r_pv,
                                   wdata: r_nx, raddr: r_place};
                    o_bwd_port = '{we: (r_nx != alle_pkg::SLOT_NONE), waddr: r_nx,
                                   wdata: r_pv, raddr: r_place};
                end
            end
            default: begin
            end
        endcase
    end

    // bookkeeping and result datapath
    always_comb begin
        n_nx         = r_nx;
        n_pv         = r_pv;
        n_new        = r_new;
        n_first      = r_first;
        n_last       = r_last;
        n_count      = r_count;
        n_freed_top  = r_freed_top;
        n_fresh      = r_fresh;
        n_in_use     = r_in_use;
        n_done       = 1'b0;
        n_res_status = alle_pkg::STAT_OK;
        n_res_slot   = r_place;
        n_res_sval   = '0;
        n_res_nx     = alle_pkg::SLOT_NONE;
        n_res_pv     = alle_pkg::SLOT_NONE;
        case (r_state)
            alle_pkg::ST_LOOK: begin
                // neighbors seen from the place entry
                if (r_mode == alle_pkg::MODE_BEFORE) begin
                    n_nx = r_place;
                    n_pv = i_bwd_rdata;
                end else if (r_mode == alle_pkg::MODE_AFTER) begin
                    n_nx = i_fwd_rdata;
                    n_pv = r_place;
                end else begin
                    n_nx = i_fwd_rdata;
                    n_pv = i_bwd_rdata;
                end
                if (r_mode == alle_pkg::MODE_INIT) begin
                    n_in_use                       = '0;
                    n_in_use[alle_pkg::SLOT_FIRST] = 1'b1;
                    n_first     = alle_pkg::SLOT_FIRST;
                    n_last      = alle_pkg::SLOT_FIRST;
                    n_count     = alle_pkg::SLOT_FIRST;
                    n_freed_top = alle_pkg::SLOT_NONE;
                    n_fresh     = alle_pkg::FRESH_INIT;
                    n_done      = 1'b1;
                    n_res_slot  = alle_pkg::SLOT_FIRST;
                    n_res_sval  = r_value;
                end else if (!is_elem) begin
                    n_done       = 1'b1;
                    n_res_status = alle_pkg::STAT_BAD;
                end else if (is_read) begin
                    n_done     = 1'b1;
                    n_res_sval = i_val_rdata;
                    n_res_nx   = i_fwd_rdata;
                    n_res_pv   = i_bwd_rdata;
                end else if (is_insert) begin
                    if (have_freed) begin
                        n_new = r_freed_top;
                    end else if (have_fresh) begin
                        n_new   = r_fresh[alle_pkg::SLOT_BITS-1:0];
                        n_fresh = r_fresh + alle_pkg::FRESH_BITS'(1);
                    end else begin
                        n_done       = 1'b1;
                        n_res_status = alle_pkg::STAT_FULL;
                        n_res_sval   = i_val_rdata;
                        n_res_nx     = i_fwd_rdata;
                        n_res_pv     = i_bwd_rdata;
                    end
                end
            end
            alle_pkg::ST_TAKE: begin
                // pop the freed stack
                n_freed_top = i_fwd_rdata;
            end
            alle_pkg::ST_WR1: begin
                if (is_insert) begin
                    n_in_use[r_new] = 1'b1;
                end else begin
                    n_in_use[r_place] = 1'b0;
                    n_freed_top       = r_place;
                end
            end
            alle_pkg::ST_WR2: begin
                n_done   = 1'b1;
                n_res_nx = r_nx;
                n_res_pv = r_pv;
                if (is_insert) begin
                    n_count    = r_count + alle_pkg::SLOT_BITS'(1);
                    n_res_slot = r_new;
                    n_res_sval = r_value;
                    if (r_mode == alle_pkg::MODE_AFTER && r_nx == alle_pkg::SLOT_NONE) begin
                        n_last = r_new;
                    end
                    if (r_mode == alle_pkg::MODE_BEFORE && r_pv == alle_pkg::SLOT_NONE) begin
                        n_first = r_new;
                    end
                end else begin
                    n_count = r_count - alle_pkg::SLOT_BITS'(1);
                    if (r_pv == alle_pkg::SLOT_NONE) begin
                        n_first = r_nx;
                    end
                    if (r_nx == alle_pkg::SLOT_NONE) begin
                        n_last = r_pv;
                    end
                end
            end
            default: begin
            end
        endcase
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= alle_pkg::ST_IDLE;
            r_first     <= alle_pkg::SLOT_NONE;
            r_last      <= alle_pkg::SLOT_NONE;
            r_count     <= '0;
            r_freed_top <= alle_pkg::SLOT_NONE;
            r_fresh     <= alle_pkg::FRESH_RESET;
            r_in_use    <= '0;
            r_done      <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_first     <= n_first;
            r_last      <= n_last;
            r_count     <= n_count;
            r_freed_top <= n_freed_top;
            r_fresh     <= n_fresh;
            r_in_use    <= n_in_use;
            r_done      <= n_done;
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        if (r_state == alle_pkg::ST_IDLE && start) begin
            r_mode  <= i_cmd.mode;
            r_place <= i_cmd.place;
            r_value <= i_cmd.value;
        end
        r_nx         <= n_nx;
        r_pv         <= n_pv;
        r_new        <= n_new;
        r_res_status <= n_res_status;
        r_res_slot   <= n_res_slot;
        r_res_sval   <= n_res_sval;
        r_res_nx     <= n_res_nx;
        r_res_pv     <= n_res_pv;
    end

    // head, tail and count are already final when the strobe is up
    assign o_done   = r_done;
    assign o_result = '{status:        r_res_status,
                        slot:          r_res_slot,
                        slot_value:    r_res_sval,
                        next_slot:     r_res_nx,
                        prev_slot:     r_res_pv,
                        head_slot:     r_first,
                        tail_slot:     r_last,
                        element_count: r_count};

endmodule

// ===== hdl/array_linked_list_engine.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// array_linked_list_engine: doubly linked list in a fixed slot table
// Slot 0 is the sentinel; freed slots are reused before fresh ones.
// ----------------------------------------------------------------------------
//  channel   | signals                  | transfer
//  ----------+--------------------------+----------------------------------
//  command   | start, busy, i_cmd       | edge with start high, busy low
//  result    | o_done, o_result         | every edge ending an o_done cycle
//
//  Read, look-up-only and bad-place commands, init and table full: result
//  strobe after ST_LOOK. Delete and insert: ST_LOOK, ST_WR1, ST_WR2; from
//  the freed stack ST_TAKE (extra read of the stack link) comes before
//  ST_WR1; writes are split by the single write port of each link memory.
//  Synchronous reset empties the list; memories need no clearing pass.
//  The result receiver cannot stall; busy is low while the strobe is up.
// ----------------------------------------------------------------------------
module array_linked_list_engine (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               start,
    output logic               busy,
    input  alle_pkg::t_cmd     i_cmd,
    output alle_pkg::t_result  o_result,
    output logic               o_done
);

    alle_pkg::t_link_port                fwd_port;
    alle_pkg::t_link_port                bwd_port;
    alle_pkg::t_val_port                 val_port;
    logic [alle_pkg::SLOT_BITS-1:0]      fwd_rdata;
    logic [alle_pkg::SLOT_BITS-1:0]      bwd_rdata;
    logic [alle_pkg::VALUE_BITS-1:0]     val_rdata;

    // sequencer
    alle_seq u_seq (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .start       (start),
        .busy        (busy),
        .i_cmd       (i_cmd),
        .o_result    (o_result),
        .o_done      (o_done),
        .o_fwd_port  (fwd_port),
        .o_bwd_port  (bwd_port),
        .o_val_port  (val_port),
        .i_fwd_rdata (fwd_rdata),
        .i_bwd_rdata (bwd_rdata),
        .i_val_rdata (val_rdata)
    );

    // forward links
    alle_ram #(
        .WIDTH (alle_pkg::SLOT_BITS),
        .DEPTH (alle_pkg::TABLE_DEPTH)
    ) u_fwd_ram (
        .i_clk   (i_clk),
        .i_we    (fwd_port.we),
        .i_waddr (fwd_port.waddr),
        .i_wdata (fwd_port.wdata),
        .i_raddr (fwd_port.raddr),
        .o_rdata (fwd_rdata)
    );

    // backward links
    alle_ram #(
        .WIDTH (alle_pkg::SLOT_BITS),
        .DEPTH (alle_pkg::TABLE_DEPTH)
    ) u_bwd_ram (
        .i_clk   (i_clk),
        .i_we    (bwd_port.we),
        .i_waddr (bwd_port.waddr),
        .i_wdata (bwd_port.wdata),
        .i_raddr (bwd_port.raddr),
        .o_rdata (bwd_rdata)
    );

    // element values
    alle_ram #(
        .WIDTH (alle_pkg::VALUE_BITS),
        .DEPTH (alle_pkg::TABLE_DEPTH)
    ) u_val_ram (
        .i_clk   (i_clk),
        .i_we    (val_port.we),
        .i_waddr (val_port.waddr),
        .i_wdata (val_port.wdata),
        .i_raddr (val_port.raddr),
        .o_rdata (val_rdata)
    );

`ifndef NO_ASSERTIONS
    // the strobe is raised only from ST_LOOK or ST_WR2, each followed by idle, so strobes never touch
    a_done_gap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |=> !o_done)
        else $error("result strobe high in two adjacent cycles");

    // an accepted command holds busy in the next cycle
    a_busy_after_start: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |=> busy)
        else $error("busy low right after a command transfer");

    // empty list has neither head nor tail
    a_empty_ends: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ((o_result.element_count == '0) == (o_result.head_slot == alle_pkg::SLOT_NONE))
        && ((o_result.element_count == '0) == (o_result.tail_slot == alle_pkg::SLOT_NONE)))
        else $error("element count disagrees with head or tail");

    // a successful operation never names the sentinel
    a_ok_slot: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_done && o_result.status == alle_pkg::STAT_OK)
        |-> (o_result.slot != alle_pkg::SLOT_NONE))
        else $error("ok result on the sentinel slot");
`endif

endmodule
